// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the class vote histogram unit.
// No dependencies; SYNTH selects the empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/cvh_pkg.sv
// Shared types and constants of the class vote histogram unit.
// No dependencies.
`default_nettype none
package cvh_pkg;

	localparam int NUM_CLASSES_DEF = 256;
	localparam int COUNT_BITS_DEF  = 32;

	// command codes
	localparam logic [2:0] CMD_ADD_LOCAL  = 3'd0;
	localparam logic [2:0] CMD_DEC_LOCAL  = 3'd1;
	localparam logic [2:0] CMD_ADD_GLOBAL = 3'd2;
	localparam logic [2:0] CMD_DEC_GLOBAL = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;
	localparam logic [2:0] CMD_CLEAR      = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  class_index;
		logic [15:0] amount;
	} item_t;

	typedef struct packed {
		logic [7:0]  best_class;
		logic [31:0] best_count;
		logic        tie_found;
		logic        is_empty;
		logic [31:0] total_votes;
	} result_t;

	// control from the sequencer to the argmax unit
	typedef struct packed {
		logic start;   // reset the running best
		logic elem;    // an entry read is on the data inputs
	} scan_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/class_vote_histogram_unit.sv
// Class vote histogram: vote table, global frequency table, argmax query.
// Depends on cvh_pkg, cvh_argmax and assert_macros.svh.
//
//   channel   | valid        | stall        | payload           | dir
//   ----------+--------------+--------------+-------------------+-----
//   command   | item_valid   | item_stall   | item   (item_t)   | in
//   result    | result_valid | result_stall | result (result_t) | out
//
// Updates: accept with table read, modify-write, result load; a bad index skips the write.
// Query: one table entry read per cycle, one port; then argmax drain and result load.
// Clear: the vote table is zeroed one entry a cycle, then the result is loaded.
// After reset a zeroing pass clears both tables; item_stall is high.
// A finished result waits in the output register while the next transaction
// is accepted; the sequencer holds in its last state only if that register is
// still occupied when the next result is ready.
`default_nettype none
`include "assert_macros.svh"
module class_vote_histogram_unit #(
	parameter int NUM_CLASSES = cvh_pkg::NUM_CLASSES_DEF,
	parameter int COUNT_BITS  = cvh_pkg::COUNT_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_stall,
	input  cvh_pkg::item_t   item,
	output logic             result_valid,
	input  wire              result_stall,
	output cvh_pkg::result_t result
);
	import cvh_pkg::*;

	localparam int CLS_W = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
	localparam int SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [CLS_W-1:0]      LAST_ADDR = CLS_W'(NUM_CLASSES - 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,   // zeroing pass, one entry a cycle
		ST_WR    = 6'b000100,   // read data back, write updated entry
		ST_SCAN  = 6'b001000,   // issue one read per entry
		ST_DRAIN = 6'b010000,   // last entry into the argmax
		ST_POST  = 6'b100000    // load result register when free
	} state_t;

	state_t                state_q;
	logic [CLS_W-1:0]      addr_q;
	logic [2:0]            cmd_q;
	logic [15:0]           amount_q;
	logic                  clr_gf_q;    // reset pass also zeroes global freqs
	logic [COUNT_BITS-1:0] vote_total_q;
	logic                  scan_rd_s1;
	logic [CLS_W-1:0]      scan_idx_s1;
	result_t               result_q;
	logic                  result_valid_q;

	// tables: {present, count} and global frequency
	logic [COUNT_BITS:0]   vote_mem [NUM_CLASSES];
	logic [COUNT_BITS-1:0] gf_mem   [NUM_CLASSES];
	logic [COUNT_BITS:0]   vote_rd_q;
	logic [COUNT_BITS-1:0] gf_rd_q;

	logic                  accept;
	logic                  idx_ok;
	logic [CLS_W-1:0]      item_addr;
	logic [CLS_W-1:0]      rd_addr;
	logic                  rd_present;
	logic [COUNT_BITS-1:0] rd_count;
	logic [COUNT_BITS-1:0] add_opnd;
	logic [SUM_W-1:0]      add_sum;
	logic [COUNT_BITS-1:0] add_sat;
	logic [SUM_W-1:0]      tot_sum;
	logic [COUNT_BITS-1:0] tot_sat;
	logic [COUNT_BITS-1:0] dec_opnd;
	logic [COUNT_BITS-1:0] dec_res;
	logic [COUNT_BITS-1:0] tot_dec;
	logic                  vote_we;
	logic [COUNT_BITS:0]   vote_wd;
	logic                  gf_we;
	logic [COUNT_BITS-1:0] gf_wd;
	logic                  slot_free;
	scan_ctl_t             scan_ctl;
	logic [CLS_W-1:0]      best_index;
	logic [COUNT_BITS-1:0] best_count;
	logic                  best_tie;
	logic                  best_found;
	logic [CLS_W+7:0]      best_index_ext;
	logic [COUNT_BITS+31:0] best_count_ext;
	logic [COUNT_BITS+31:0] total_ext;
	logic [CLS_W+7:0]      item_idx_ext;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign idx_ok     = (32'(item.class_index) < NUM_CLASSES);
	assign item_idx_ext = {{CLS_W{1'b0}}, item.class_index};
	assign item_addr  = item_idx_ext[CLS_W-1:0];
	// the entry addressed by a new transaction is read in its accept cycle
	assign rd_addr    = (state_q == ST_IDLE) ? item_addr : addr_q;
	assign slot_free  = !result_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (vote_we) begin
			vote_mem[addr_q] <= vote_wd;
		end
		vote_rd_q <= vote_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (gf_we) begin
			gf_mem[addr_q] <= gf_wd;
		end
		gf_rd_q <= gf_mem[rd_addr];
	end

	// read-modify-write datapath, saturating both ways
	assign rd_present = vote_rd_q[COUNT_BITS];
	assign rd_count   = vote_rd_q[COUNT_BITS-1:0];
	assign add_opnd   = (cmd_q == CMD_ADD_GLOBAL) ? gf_rd_q :
	                    (rd_present ? rd_count : '0);
	assign add_sum    = SUM_W'(add_opnd) + SUM_W'(amount_q);
	assign add_sat    = (add_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : add_sum[COUNT_BITS-1:0];
	assign tot_sum    = SUM_W'(vote_total_q) + SUM_W'(amount_q);
	assign tot_sat    = (tot_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : tot_sum[COUNT_BITS-1:0];
	assign dec_opnd   = (cmd_q == CMD_DEC_GLOBAL) ? gf_rd_q : rd_count;
	assign dec_res    = (dec_opnd == '0) ? '0 : dec_opnd - COUNT_BITS'(1);
	assign tot_dec    = (vote_total_q == '0) ? '0 : vote_total_q - COUNT_BITS'(1);

	always_comb begin
		vote_we = 1'b0;
		vote_wd = '0;
		gf_we   = 1'b0;
		gf_wd   = '0;
		case (state_q)
			ST_CLEAR: begin
				vote_we = 1'b1;
				gf_we   = clr_gf_q;
			end
			ST_WR: begin
				case (cmd_q)
					CMD_ADD_LOCAL: begin
						vote_we = 1'b1;
						vote_wd = {1'b1, add_sat};
					end
					CMD_DEC_LOCAL: begin
						// absent entry stays absent
						vote_we = rd_present;
						vote_wd = {1'b1, dec_res};
					end
					CMD_ADD_GLOBAL: begin
						gf_we = 1'b1;
						gf_wd = add_sat;
					end
					CMD_DEC_GLOBAL: begin
						gf_we = 1'b1;
						gf_wd = dec_res;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			addr_q         <= '0;
			clr_gf_q       <= 1'b1;
			vote_total_q   <= '0;
			scan_rd_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			scan_rd_s1 <= (state_q == ST_SCAN);
			// result register: load when free, else drop once taken
			if (state_q == ST_POST && slot_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd inside {CMD_ADD_LOCAL, CMD_DEC_LOCAL,
						                     CMD_ADD_GLOBAL, CMD_DEC_GLOBAL}) begin
							addr_q  <= item_addr;
							state_q <= idx_ok ? ST_WR : ST_POST;
						end else if (item.cmd == CMD_QUERY) begin
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end else if (item.cmd == CMD_CLEAR) begin
							addr_q       <= '0;
							clr_gf_q     <= 1'b0;
							vote_total_q <= '0;
							state_q      <= ST_CLEAR;
						end else begin
							state_q <= ST_POST;
						end
					end
				end
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						clr_gf_q <= 1'b0;
						// the reset pass produces no result
						state_q  <= clr_gf_q ? ST_IDLE : ST_POST;
					end else begin
						addr_q <= addr_q + CLS_W'(1);
					end
				end
				ST_WR: begin
					if (cmd_q == CMD_ADD_LOCAL) begin
						vote_total_q <= tot_sat;
					end else if (cmd_q == CMD_DEC_LOCAL && rd_present) begin
						vote_total_q <= tot_dec;
					end
					state_q <= ST_POST;
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + CLS_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction payload and scan pipeline registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.cmd;
			amount_q <= item.amount;
		end
		scan_idx_s1 <= addr_q;
		if (state_q == ST_POST && slot_free) begin
			result_q <= result_t'{
				best_class:  (cmd_q == CMD_QUERY) ? best_index_ext[7:0] : 8'd0,
				best_count:  (cmd_q == CMD_QUERY) ? best_count_ext[31:0] : 32'd0,
				tie_found:   (cmd_q == CMD_QUERY) && best_tie,
				is_empty:    (cmd_q == CMD_QUERY) && !best_found,
				total_votes: total_ext[31:0]
			};
		end
	end

	assign scan_ctl.start = accept && (item.cmd == CMD_QUERY);
	assign scan_ctl.elem  = scan_rd_s1;

	cvh_argmax #(
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (CLS_W)
	) u_argmax (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (scan_ctl),
		.elem_present (rd_present),
		.elem_count   (rd_count),
		.elem_gf      (gf_rd_q),
		.elem_index   (scan_idx_s1),
		.best_index   (best_index),
		.best_count   (best_count),
		.tie          (best_tie),
		.found        (best_found)
	);

	// fixed output widths: zero-extend, then keep the low bits
	assign best_index_ext = {8'd0, best_index};
	assign best_count_ext = {32'd0, best_count};
	assign total_ext      = {32'd0, vote_total_q};

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_IMPL(a_vote_wr_states, clk, arst_n, vote_we, (state_q == ST_CLEAR || state_q == ST_WR))
	`ASSERT_CLK(a_accept_leaves_idle, clk, arst_n, accept |=> (state_q != ST_IDLE))
	`ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n, state_q == ST_CLEAR, item_stall)

endmodule
`default_nettype wire

// File: hw/rtl/cvh_argmax.sv
// Running argmax over the vote table entries streamed during a query.
// Depends on cvh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cvh_argmax #(
	parameter int COUNT_BITS = cvh_pkg::COUNT_BITS_DEF,
	parameter int IDX_W      = 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  cvh_pkg::scan_ctl_t     ctl,
	input  wire                    elem_present,
	input  wire  [COUNT_BITS-1:0]  elem_count,
	input  wire  [COUNT_BITS-1:0]  elem_gf,
	input  wire  [IDX_W-1:0]       elem_index,
	output logic [IDX_W-1:0]       best_index,
	output logic [COUNT_BITS-1:0]  best_count,
	output logic                   tie,
	output logic                   found
);
	import cvh_pkg::*;

	logic [IDX_W-1:0]      best_idx_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [COUNT_BITS-1:0] best_gf_q;   // global freq of the current best
	logic                  tie_q;
	logic                  found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tie_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.start) begin
			tie_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.elem && elem_present) begin
			if (!found_q || elem_count > best_cnt_q) begin
				found_q <= 1'b1;
				tie_q   <= 1'b0;
			end else if (elem_count == best_cnt_q) begin
				tie_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			best_idx_q <= '0;
			best_cnt_q <= '0;
			best_gf_q  <= '0;
		end else if (ctl.elem && elem_present) begin
			if (!found_q || elem_count > best_cnt_q) begin
				best_idx_q <= elem_index;
				best_cnt_q <= elem_count;
				best_gf_q  <= elem_gf;
			end else if (elem_count == best_cnt_q && elem_gf > best_gf_q) begin
				// tie broken toward the higher global frequency
				best_idx_q <= elem_index;
				best_gf_q  <= elem_gf;
			end
		end
	end

	assign best_index = best_idx_q;
	assign best_count = best_cnt_q;
	assign tie        = tie_q;
	assign found      = found_q;

	`ASSERT_IMPL(a_tie_needs_found, clk, arst_n, tie_q, found_q)
	`ASSERT_CLK(a_start_clears, clk, arst_n, ctl.start |=> (!found_q && !tie_q))
	`ASSERT_IMPL(a_found_falls_on_start, clk, arst_n, $fell(found_q), $past(ctl.start))

endmodule
`default_nettype wire
